// ===== hdl/wmoc_pkg.sv =====
// Shared types, constants and codes of the windowed median outlier check.
`default_nettype none
package wmoc_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int MASS_W     = 32;
    localparam int TIME_W     = 40;
    localparam int EXPO_W     = 31;
    localparam int WIN_W      = 32;
    localparam int THR_W      = 16;
    localparam int SPAN_W     = WIN_W + 1;
    localparam int HIGH_W     = MASS_W + 1;
    localparam int FACTOR_W   = THR_W + 1;
    localparam int PROD_W     = MASS_W + FACTOR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Parameter defaults
    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_MIN_ENTRIES  = 3;

    // Register reset values and indexes
    localparam logic [WIN_W-1:0]     RST_TIME_WINDOW = WIN_W'(20000);
    localparam logic [THR_W-1:0]     RST_THRESHOLD   = THR_W'(32768);
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = CFG_IDX_W'(1);

    // 1.0 in Q1.16, one bit wider than the threshold
    localparam logic [FACTOR_W-1:0] ONE_Q16 = FACTOR_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 2'd0,
        OP_CHECK    = 2'd1,
        OP_EXPOSURE = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    // Command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_DROP,
        CELL_WRITE,
        CELL_LOAD,
        CELL_RANK,
        CELL_SCAN
    } t_cell_op;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        logic [MASS_W-1:0] wr_mass;
        logic [TIME_W-1:0] wr_stamp;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ===== hdl/wmoc_cell.sv =====
// One cell of the sample row: a stored entry plus a rank-counting scan slot.
`default_nettype none
module wmoc_cell #(
    parameter int WINDOW_DEPTH = wmoc_pkg::DEF_WINDOW_DEPTH,
    parameter int IDX          = 0
) (
    input  wire logic                                  i_clk,
    input  wire wmoc_pkg::t_cell_cmd                   i_cmd,
    input  wire logic [$clog2(WINDOW_DEPTH+1)-1:0]     i_count,
    input  wire logic [$clog2(WINDOW_DEPTH+1)-1:0]     i_step,
    input  wire wmoc_pkg::t_entry                      i_head,
    input  wire wmoc_pkg::t_entry                      i_next,
    input  wire logic [wmoc_pkg::MASS_W-1:0]           i_next_scan_mass,
    input  wire logic [$clog2(WINDOW_DEPTH)-1:0]       i_next_scan_rank,
    output wmoc_pkg::t_entry                           o_entry,
    output logic [wmoc_pkg::MASS_W-1:0]                o_scan_mass,
    output logic [$clog2(WINDOW_DEPTH)-1:0]            o_scan_rank
);
    import wmoc_pkg::*;

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    t_entry            r_entry, n_entry;
    logic [MASS_W-1:0] r_scan_mass, n_scan_mass;
    logic [IW-1:0]     r_scan_rank, n_scan_rank;
    logic              w_before;

    // The head entry orders before this one: smaller, or equal and earlier in the row
    assign w_before = (i_head.mass < r_scan_mass) ||
                      ((i_head.mass == r_scan_mass) && (i_step < MY_IDX));

    always_comb begin
        n_entry     = r_entry;
        n_scan_mass = r_scan_mass;
        n_scan_rank = r_scan_rank;
        case (i_cmd.op)
            CELL_DROP: begin
                n_entry = i_next;
            end
            CELL_WRITE: begin
                if (i_count == MY_IDX) begin
                    n_entry.mass  = i_cmd.wr_mass;
                    n_entry.stamp = i_cmd.wr_stamp;
                end
            end
            CELL_LOAD: begin
                n_scan_mass = r_entry.mass;
                n_scan_rank = '0;
            end
            CELL_RANK: begin
                // rotate the occupied part of the row, tail takes the head
                n_entry = (i_count == MY_NEXT) ? i_head : i_next;
                if (w_before) begin
                    n_scan_rank = r_scan_rank + IW'(1);
                end
            end
            CELL_SCAN: begin
                n_scan_mass = i_next_scan_mass;
                n_scan_rank = i_next_scan_rank;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry     <= n_entry;
        r_scan_mass <= n_scan_mass;
        r_scan_rank <= n_scan_rank;
    end

    assign o_entry     = r_entry;
    assign o_scan_mass = r_scan_mass;
    assign o_scan_rank = r_scan_rank;

endmodule
`default_nettype wire

// ===== hdl/wmoc_limits.sv =====
// Limit products of the median and the outlier compare against them.
`default_nettype none
module wmoc_limits (
    input  wire logic                             i_clk,
    input  wire logic [wmoc_pkg::MASS_W-1:0]      i_median,
    input  wire logic [wmoc_pkg::THR_W-1:0]       i_threshold,
    input  wire logic [wmoc_pkg::MASS_W-1:0]      i_mass,
    output logic [wmoc_pkg::MASS_W-1:0]           o_low_limit,
    output logic [wmoc_pkg::HIGH_W-1:0]           o_high_limit,
    output logic                                  o_outlier
);
    import wmoc_pkg::*;

    logic [FACTOR_W-1:0] w_lo_factor, w_hi_factor;
    logic [PROD_W-1:0]   r_lo_num, r_hi_num;
    logic [PROD_W-1:0]   w_scaled;

    assign w_lo_factor = ONE_Q16 - FACTOR_W'(i_threshold);
    assign w_hi_factor = ONE_Q16 + FACTOR_W'(i_threshold);

    always_ff @(posedge i_clk) begin
        r_lo_num <= PROD_W'(i_median) * PROD_W'(w_lo_factor);
        r_hi_num <= PROD_W'(i_median) * PROD_W'(w_hi_factor);
    end

    // compare against the exact limits, before dropping the fraction
    assign w_scaled     = PROD_W'({i_mass, 16'h0000});
    assign o_outlier    = (w_scaled < r_lo_num) || (w_scaled > r_hi_num);
    assign o_low_limit  = r_lo_num[MASS_W+15:16];
    assign o_high_limit = r_hi_num[HIGH_W+15:16];

endmodule
`default_nettype wire

// ===== hdl/windowed_median_outlier_check_top.sv =====
// Top level of the windowed median outlier check: control, cell row and limits.
`default_nettype none
// The block keeps up to WINDOW_DEPTH timestamped mass samples in a row of cells, oldest at
// cell 0, and answers one result beat for every input beat. Append drops expired entries
// from the oldest end one per cycle, drops the oldest if still full, then stores the new
// sample. Check finds the upper median (rank count/2) with a rank pass that rotates the
// row once while every cell counts the entries ordered before it, then an extraction pass
// that shifts the ranks out until the median appears, then a multiply and a compare. Set
// exposure and reset store go from idle straight to the output state. One item is worked
// on at a time; the input is stalled until its result sits in the output register, which
// can hold a beat while the next item is accepted. The configuration port is always
// ready; write it only while the block is idle.
module windowed_median_outlier_check_top #(
    parameter int WINDOW_DEPTH = wmoc_pkg::DEF_WINDOW_DEPTH,
    parameter int MIN_ENTRIES  = wmoc_pkg::DEF_MIN_ENTRIES
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input item channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [wmoc_pkg::OP_W-1:0]          i_op,
    input  wire logic [wmoc_pkg::MASS_W-1:0]        i_mass,
    input  wire logic [wmoc_pkg::TIME_W-1:0]        i_now_ms,
    input  wire logic [wmoc_pkg::EXPO_W-1:0]        i_exposure,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_checked,
    output logic                                    o_outlier,
    output logic [wmoc_pkg::MASS_W-1:0]             o_low_limit,
    output logic [wmoc_pkg::MASS_W-1:0]             o_median_mass,
    output logic [wmoc_pkg::HIGH_W-1:0]             o_high_limit,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [wmoc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [wmoc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wmoc_pkg::*;

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_DEPTH);
    localparam int CMP_W = TIME_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXPIRE,
        S_WRITE,
        S_LOAD,
        S_RANK,
        S_PICK,
        S_MUL,
        S_CMP,
        S_EMIT
    } t_state;

    // control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_step, n_step;
    logic [EXPO_W-1:0]  r_last_expo, n_last_expo;
    logic [WIN_W-1:0]   r_window, n_window;
    logic [THR_W-1:0]   r_threshold, n_threshold;
    logic               r_out_valid, n_out_valid;

    // item and result payload
    logic [MASS_W-1:0]  r_mass, n_mass;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [MASS_W-1:0]  r_median, n_median;
    logic               r_res_checked, n_res_checked;
    logic               r_res_outlier, n_res_outlier;
    logic [MASS_W-1:0]  r_res_low, n_res_low;
    logic [HIGH_W-1:0]  r_res_high, n_res_high;
    logic               r_out_checked, n_out_checked;
    logic               r_out_outlier, n_out_outlier;
    logic [MASS_W-1:0]  r_out_low, n_out_low;
    logic [MASS_W-1:0]  r_out_median, n_out_median;
    logic [HIGH_W-1:0]  r_out_high, n_out_high;

    // cell row
    t_cell_cmd          w_cmd;
    t_entry             w_entry     [WINDOW_DEPTH+1];
    logic [MASS_W-1:0]  w_scan_mass [WINDOW_DEPTH+1];
    logic [IW-1:0]      w_scan_rank [WINDOW_DEPTH+1];

    logic               w_in_acc;
    logic               w_expired;
    logic [MASS_W-1:0]  w_lim_low;
    logic [HIGH_W-1:0]  w_lim_high;
    logic               w_lim_outlier;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Row of cells; cell 0 holds the oldest entry, the end of the row feeds zeros.
    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        wmoc_cell #(
            .WINDOW_DEPTH (WINDOW_DEPTH),
            .IDX          (g)
        ) u_cell (
            .i_clk            (i_clk),
            .i_cmd            (w_cmd),
            .i_count          (r_count),
            .i_step           (r_step),
            .i_head           (w_entry[0]),
            .i_next           (w_entry[g+1]),
            .i_next_scan_mass (w_scan_mass[g+1]),
            .i_next_scan_rank (w_scan_rank[g+1]),
            .o_entry          (w_entry[g]),
            .o_scan_mass      (w_scan_mass[g]),
            .o_scan_rank      (w_scan_rank[g])
        );
    end

    assign w_entry[WINDOW_DEPTH]     = '0;
    assign w_scan_mass[WINDOW_DEPTH] = '0;
    assign w_scan_rank[WINDOW_DEPTH] = '0;

    // Products register at the end of S_MUL, the compare is read in S_CMP.
    wmoc_limits u_limits (
        .i_clk        (i_clk),
        .i_median     (r_median),
        .i_threshold  (r_threshold),
        .i_mass       (r_mass),
        .o_low_limit  (w_lim_low),
        .o_high_limit (w_lim_high),
        .o_outlier    (w_lim_outlier)
    );

    // Oldest entry is expired when stamp + 2*window < now, all without wrap.
    assign w_expired = (r_count != '0) &&
                       ((CMP_W'(w_entry[0].stamp) + CMP_W'({r_window, 1'b0})) <
                        CMP_W'(r_now));

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_step        = r_step;
        n_last_expo   = r_last_expo;
        n_window      = r_window;
        n_threshold   = r_threshold;
        n_out_valid   = r_out_valid;
        n_mass        = r_mass;
        n_now         = r_now;
        n_median      = r_median;
        n_res_checked = r_res_checked;
        n_res_outlier = r_res_outlier;
        n_res_low     = r_res_low;
        n_res_high    = r_res_high;
        n_out_checked = r_out_checked;
        n_out_outlier = r_out_outlier;
        n_out_low     = r_out_low;
        n_out_median  = r_out_median;
        n_out_high    = r_out_high;

        w_cmd.op       = CELL_HOLD;
        w_cmd.wr_mass  = r_mass;
        w_cmd.wr_stamp = r_now;

        // configuration writes; indexes beyond the list are ignored
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TIME_WINDOW: n_window    = i_cfg_data[WIN_W-1:0];
                REG_THRESHOLD:   n_threshold = i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end

        // drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mass        = i_mass;
                    n_now         = i_now_ms;
                    n_res_checked = 1'b0;
                    n_res_outlier = 1'b0;
                    n_res_low     = '0;
                    n_res_high    = '0;
                    n_median      = '0;
                    case (t_op'(i_op))
                        OP_APPEND: begin
                            n_state = S_EXPIRE;
                        end
                        OP_CHECK: begin
                            if (32'(r_count) >= 32'(MIN_ENTRIES)) begin
                                n_state = S_LOAD;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        OP_EXPOSURE: begin
                            if (i_exposure != r_last_expo) begin
                                n_last_expo = i_exposure;
                                n_count     = '0;
                            end
                            n_state = S_EMIT;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_EXPIRE: begin
                // expiry stops at the first live entry; a full row then gives up its oldest
                if (w_expired) begin
                    w_cmd.op = CELL_DROP;
                    n_count  = r_count - CW'(1);
                end else if (r_count == FULL_CNT) begin
                    w_cmd.op = CELL_DROP;
                    n_count  = r_count - CW'(1);
                    n_state  = S_WRITE;
                end else begin
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                w_cmd.op = CELL_WRITE;
                n_count  = r_count + CW'(1);
                n_state  = S_EMIT;
            end
            S_LOAD: begin
                w_cmd.op = CELL_LOAD;
                n_step   = '0;
                n_state  = S_RANK;
            end
            S_RANK: begin
                // head carries entry r_step; a full turn restores the row
                w_cmd.op = CELL_RANK;
                n_step   = r_step + CW'(1);
                if (r_step == r_count - CW'(1)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // ranks of the occupied slots form a permutation, so exactly one of them matches
                w_cmd.op = CELL_SCAN;
                if (w_scan_rank[0] == IW'(r_count >> 1)) begin
                    n_median = w_scan_mass[0];
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_res_checked = 1'b1;
                n_res_outlier = w_lim_outlier;
                n_res_low     = w_lim_low;
                n_res_high    = w_lim_high;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                // advance into the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_checked = r_res_checked;
                    n_out_outlier = r_res_outlier;
                    n_out_low     = r_res_low;
                    n_out_median  = r_median;
                    n_out_high    = r_res_high;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_last_expo <= '0;
            r_window    <= RST_TIME_WINDOW;
            r_threshold <= RST_THRESHOLD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_last_expo <= n_last_expo;
            r_window    <= n_window;
            r_threshold <= n_threshold;
            r_out_valid <= n_out_valid;
        end
        r_mass        <= n_mass;
        r_now         <= n_now;
        r_median      <= n_median;
        r_res_checked <= n_res_checked;
        r_res_outlier <= n_res_outlier;
        r_res_low     <= n_res_low;
        r_res_high    <= n_res_high;
        r_out_checked <= n_out_checked;
        r_out_outlier <= n_out_outlier;
        r_out_low     <= n_out_low;
        r_out_median  <= n_out_median;
        r_out_high    <= n_out_high;
    end

    assign o_out_valid   = r_out_valid;
    assign o_checked     = r_out_checked;
    assign o_outlier     = r_out_outlier;
    assign o_low_limit   = r_out_low;
    assign o_median_mass = r_out_median;
    assign o_high_limit  = r_out_high;

    // Fill count never passes the row length.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count beyond row length");

    // One item at a time: an accepted beat stalls the input on the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("second item accepted while busy");

    // A checked result brackets its median between the limits.
    a_limit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_checked) |->
            ((o_low_limit <= o_median_mass) && (HIGH_W'(o_median_mass) <= o_high_limit)))
        else $error("median outside its own limits");

    // An unchecked result carries nothing.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_checked) |->
            (!o_outlier && (o_median_mass == '0) && (o_low_limit == '0) &&
             (o_high_limit == '0)))
        else $error("unchecked result not cleared");

endmodule
`default_nettype wire
